// File: src/sbtt_pkg.sv
`timescale 1ns / 1ps

package sbtt_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int COORD_BITS_DEF  = 32;
    localparam int ONE_Q16         = 65536;

    localparam logic [16:0] FRAC_ONE = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    localparam logic [2:0] SIDE_NONE  = 3'd0;
    localparam logic [2:0] SIDE_NEG_X = 3'd1;

    localparam int         PADDR_BITS   = 3;
    localparam logic [2:0] ADDR_IGNORED = 3'd0;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         slot;
        logic [15:0]        entity;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic               start_overlap;
        logic [16:0]        fraction;
        logic [2:0]         side;
        logic [15:0]        hit_entity;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } t_out;

endpackage

// File: src/sbtt_table.sv
`timescale 1ns / 1ps

module sbtt_table #(
    parameter int TABLE_SLOTS = sbtt_pkg::TABLE_SLOTS_DEF,
    parameter int CW          = 32,
    localparam int SW         = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic                 i_wr_clear,
    input  logic [SW-1:0]        i_wr_idx,
    input  logic [15:0]          i_wr_entity,
    input  logic [5:0][CW-1:0]   i_wr_corners,
    input  logic [SW-1:0]        i_rd_idx,
    output logic                 o_rd_valid,
    output logic [15:0]          o_rd_entity,
    output logic [5:0][CW-1:0]   o_rd_corners
);

    localparam int RW = 16 + 6 * CW;

    logic [RW-1:0]          r_mem [TABLE_SLOTS];
    logic [RW-1:0]          r_rd_row;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic                   r_rd_valid;

    // row store: entity id on top, six corners below
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_clear) begin
            r_mem[i_wr_idx] <= {i_wr_entity, i_wr_corners};
        end
        r_rd_row <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= !i_wr_clear;
            end
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_valid   = r_rd_valid;
    assign o_rd_entity  = r_rd_row[RW-1 -: 16];
    assign o_rd_corners = r_rd_row[6*CW-1:0];

endmodule

// File: src/sbtt_div.sv
`timescale 1ns / 1ps

module sbtt_div #(
    parameter int CW  = 32,
    localparam int QW = CW + 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW:0]   i_num,
    input  logic signed [CW-1:0] i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_quot
);

    // dividend is num * 2^16, one quotient bit per cycle
    localparam int NW   = CW + 17;
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_n;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_dm;
    logic            r_neg;

    logic [CW:0]   num_mag;
    logic [CW-1:0] den_mag;
    logic [CW:0]   trial;
    logic          ge;
    logic [CW-1:0] n_rem;
    logic [QW-1:0] qm;

    assign num_mag = i_num[CW] ? (~$unsigned(i_num) + 1'b1) : $unsigned(i_num);
    assign den_mag = i_den[CW-1] ? (~$unsigned(i_den) + 1'b1) : $unsigned(i_den);

    assign trial = {r_rem, r_n[NW-1]};
    assign ge    = trial >= {1'b0, r_dm};
    assign n_rem = ge ? CW'(trial - {1'b0, r_dm}) : CW'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
                r_n    <= {num_mag, 16'b0};
                r_rem  <= '0;
                r_dm   <= den_mag;
                r_neg  <= i_num[CW] ^ i_den[CW-1];
            end else if (r_busy) begin
                r_n   <= {r_n[NW-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // floor: -q when exact, else -q - 1 which is ~q
    assign qm     = {1'b0, r_n};
    assign o_quot = $signed(r_neg ? (~qm + QW'(r_rem == '0)) : qm);
    assign o_done = r_done;

endmodule

// File: src/sbtt_core.sv
`timescale 1ns / 1ps

module sbtt_core #(
    parameter int TABLE_SLOTS = sbtt_pkg::TABLE_SLOTS_DEF,
    parameter int CW          = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sbtt_pkg::t_in    i_item,
    input  logic [15:0]      i_ignored,
    output logic             o_busy,
    output logic             o_res_valid,
    output sbtt_pkg::t_out   o_res,
    input  logic             i_res_ack
);

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int QW = CW + 18;
    localparam int PW = CW + 18;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_INS  = 4'd3;
    localparam logic [3:0] S_AX   = 4'd4;
    localparam logic [3:0] S_DIV1 = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_NEXT = 4'd9;
    localparam logic [3:0] S_OFS  = 4'd10;
    localparam logic [3:0] S_OSAT = 4'd11;
    localparam logic [3:0] S_RESP = 4'd12;

    localparam logic signed [QW-1:0] ENTRY_INIT = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] LEAVE_INIT = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_ONE      = QW'(sbtt_pkg::ONE_Q16);
    localparam logic signed [CW+1:0] SAT_HI     = (CW+2)'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [CW+1:0] SAT_LO     = ~SAT_HI;

    logic [3:0]          r_state;
    logic [SW-1:0]       r_idx;
    logic [1:0]          r_k;
    logic [5:0][CW-1:0]  r_box;
    logic [2:0][CW-1:0]  r_mv;
    logic signed [QW-1:0] r_entry;
    logic signed [QW-1:0] r_leave;
    logic signed [QW-1:0] r_t1;
    logic signed [QW-1:0] r_t2;
    logic [2:0]          r_cside;
    logic                r_hit;
    logic                r_inside;
    logic [16:0]         r_frac;
    logic [2:0]          r_side;
    logic [15:0]         r_ent;
    logic [2:0][CW-1:0]  r_off;
    logic signed [PW-1:0] r_prod;

    logic               wr_en;
    logic               slot_ok;
    logic [5:0][CW-1:0] wr_corners;
    logic               t_valid;
    logic [15:0]        t_entity;
    logic [5:0][CW-1:0] t_corners;

    logic                 div_start;
    logic signed [CW:0]   div_num;
    logic                 div_done;
    logic signed [QW-1:0] div_quot;

    logic signed [CW-1:0] mmin, mmax, mvk, smin, smax;
    logic signed [CW:0]   d1, d2;
    logic signed [QW-1:0] lo, hi, n_entry, n_leave;
    logic                 over;
    logic [2:0]           ins_side;
    logic signed [CW+1:0] sh;
    logic [CW-1:0]        sat;

    assign slot_ok = int'(i_item.slot) < TABLE_SLOTS;
    assign wr_en   = (r_state == S_IDLE) && i_start && (i_item.opcode == sbtt_pkg::OP_WRITE)
                     && slot_ok;
    assign wr_corners = {CW'(i_item.box_max_z), CW'(i_item.box_max_y), CW'(i_item.box_max_x),
                         CW'(i_item.box_min_z), CW'(i_item.box_min_y), CW'(i_item.box_min_x)};

    sbtt_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CW          (CW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_clear   (i_item.entity == 16'd0),
        .i_wr_idx     (SW'(i_item.slot)),
        .i_wr_entity  (i_item.entity),
        .i_wr_corners (wr_corners),
        .i_rd_idx     (r_idx),
        .o_rd_valid   (t_valid),
        .o_rd_entity  (t_entity),
        .o_rd_corners (t_corners)
    );

    // current axis operands
    assign mmin = $signed(r_box[3'(r_k)]);
    assign mmax = $signed(r_box[3'(r_k) + 3'd3]);
    assign mvk  = $signed(r_mv[r_k]);
    assign smin = $signed(t_corners[3'(r_k)]);
    assign smax = $signed(t_corners[3'(r_k) + 3'd3]);
    assign d1   = $signed({smin[CW-1], smin}) - $signed({mmax[CW-1], mmax});
    assign d2   = $signed({smax[CW-1], smax}) - $signed({mmin[CW-1], mmin});

    assign div_start = ((r_state == S_AX) && (mvk != '0)) || ((r_state == S_DIV1) && div_done);
    assign div_num   = (r_state == S_AX) ? d1 : d2;

    sbtt_div #(
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (mvk),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign lo      = (r_t1 < r_t2) ? r_t1 : r_t2;
    assign hi      = (r_t1 < r_t2) ? r_t2 : r_t1;
    assign n_entry = (lo > r_entry) ? lo : r_entry;
    assign n_leave = (hi < r_leave) ? hi : r_leave;

    // strict start overlap and face of least penetration
    always_comb begin
        logic signed [CW-1:0] a_min, a_max, b_min, b_max;
        logic signed [CW:0]   pos, neg, dep, best;
        over     = 1'b1;
        ins_side = sbtt_pkg::SIDE_NONE;
        best     = '0;
        for (int k = 0; k < 3; k++) begin
            a_min = $signed(r_box[k]);
            a_max = $signed(r_box[k+3]);
            b_min = $signed(t_corners[k]);
            b_max = $signed(t_corners[k+3]);
            if (!(a_max > b_min && a_min < b_max)) begin
                over = 1'b0;
            end
            pos = $signed({b_max[CW-1], b_max}) - $signed({a_min[CW-1], a_min});
            neg = $signed({a_max[CW-1], a_max}) - $signed({b_min[CW-1], b_min});
            dep = (pos < neg) ? pos : neg;
            if (k == 0 || dep < best) begin
                best     = dep;
                ins_side = sbtt_pkg::SIDE_NEG_X + 3'(2 * k) + 3'(pos < neg);
            end
        end
    end

    // offset = floor(move * fraction / 2^16), saturated
    assign sh  = r_prod[PW-1:16];
    assign sat = (sh > SAT_HI) ? CW'(SAT_HI) : ((sh < SAT_LO) ? CW'(SAT_LO) : CW'(sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_box <= {CW'(i_item.box_max_z), CW'(i_item.box_max_y),
                                  CW'(i_item.box_max_x), CW'(i_item.box_min_z),
                                  CW'(i_item.box_min_y), CW'(i_item.box_min_x)};
                        r_mv     <= {CW'(i_item.move_z), CW'(i_item.move_y), CW'(i_item.move_x)};
                        r_hit    <= 1'b0;
                        r_inside <= 1'b0;
                        r_side   <= sbtt_pkg::SIDE_NONE;
                        r_ent    <= '0;
                        r_idx    <= '0;
                        if (i_item.opcode == sbtt_pkg::OP_WRITE) begin
                            r_frac  <= '0;
                            r_off   <= '0;
                            r_state <= S_RESP;
                        end else begin
                            r_frac  <= sbtt_pkg::FRAC_ONE;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!t_valid || t_entity == i_ignored) begin
                        r_state <= S_NEXT;
                    end else if (over) begin
                        r_state <= S_INS;
                    end else begin
                        r_entry <= ENTRY_INIT;
                        r_leave <= LEAVE_INIT;
                        r_cside <= sbtt_pkg::SIDE_NONE;
                        r_k     <= '0;
                        r_state <= S_AX;
                    end
                end
                S_INS: begin
                    r_hit    <= 1'b1;
                    r_inside <= 1'b1;
                    r_frac   <= '0;
                    r_side   <= ins_side;
                    r_ent    <= t_entity;
                    r_k      <= '0;
                    r_state  <= S_OFS;
                end
                S_AX: begin
                    if (mvk != '0) begin
                        r_state <= S_DIV1;
                    end else if (mmax >= smin && mmin <= smax) begin
                        if (r_k == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_t1    <= div_quot;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_t2    <= div_quot;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_entry <= n_entry;
                    r_leave <= n_leave;
                    if (lo > r_entry) begin
                        r_cside <= sbtt_pkg::SIDE_NEG_X + {r_k, 1'b0} + 3'(mvk < 0);
                    end
                    if (n_entry > n_leave) begin
                        r_state <= S_NEXT;
                    end else if (r_k == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_AX;
                    end
                end
                S_FIN: begin
                    if (!(r_entry < 0 || r_entry > Q_ONE || r_entry > r_leave)) begin
                        if (!r_hit || r_entry[16:0] < r_frac) begin
                            r_hit  <= 1'b1;
                            r_frac <= r_entry[16:0];
                            r_side <= r_cside;
                            r_ent  <= t_entity;
                        end
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_idx == SW'(TABLE_SLOTS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_OFS;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OFS: begin
                    r_prod  <= mvk * $signed({1'b0, r_frac});
                    r_state <= S_OSAT;
                end
                S_OSAT: begin
                    r_off[r_k] <= sat;
                    if (r_k == 2'd2) begin
                        r_state <= S_RESP;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_OFS;
                    end
                end
                S_RESP: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESP);

    always_comb begin
        o_res               = '0;
        o_res.hit           = r_hit;
        o_res.start_overlap = r_inside;
        o_res.fraction      = r_frac;
        o_res.side          = r_side;
        o_res.hit_entity    = r_ent;
        o_res.offset_x      = 32'($signed(r_off[0]));
        o_res.offset_y      = 32'($signed(r_off[1]));
        o_res.offset_z      = 32'($signed(r_off[2]));
    end

endmodule

// File: src/swept_box_trace_table_top.sv
`timescale 1ns / 1ps
// a write transaction moves from idle straight to the result state once accepted
// a trace walks every slot, stopping early at a start overlap: it reads, checks and steps
// past each one, and if swept tests each still axis directly and runs two divisions per
// moving axis in the bit-serial divider; the offsets are computed last
// throughput: one transaction at a time, the next accepted once the result is registered
// reset clears the slot valid bits, the register and all control; table rows need no reset

module swept_box_trace_table_top #(
    parameter int TABLE_SLOTS = sbtt_pkg::TABLE_SLOTS_DEF,
    parameter int COORD_BITS  = sbtt_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sbtt_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sbtt_pkg::t_out                      o_out_data,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [sbtt_pkg::PADDR_BITS-1:0]     i_paddr,
    input  logic [31:0]                         i_pwdata,
    output logic [31:0]                         o_prdata,
    output logic                                o_pready
);

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

    logic [15:0]     r_ignored;
    logic            r_out_valid;
    sbtt_pkg::t_out  r_out_data;

    logic            in_accept;
    logic            busy;
    logic            res_valid;
    logic            res_take;
    sbtt_pkg::t_out  res;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == sbtt_pkg::ADDR_IGNORED) ? {16'b0, r_ignored} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignored <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr == sbtt_pkg::ADDR_IGNORED) begin
            r_ignored <= i_pwdata[15:0];
        end
    end

    assign in_accept  = i_in_valid && !busy;
    assign o_in_stall = busy;

    sbtt_core #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CW          (CW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_item      (i_in_data),
        .i_ignored   (r_ignored),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ack   (res_take)
    );

    // output register frees the core while a result waits downstream
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("core not busy after an accepted transaction");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.start_overlap |->
            o_out_data.hit && o_out_data.fraction == '0)
        else $error("start overlap without hit at fraction zero");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |-> o_out_data.fraction <= sbtt_pkg::FRAC_ONE)
        else $error("hit fraction above one");

    a_side_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |->
            o_out_data.side == sbtt_pkg::SIDE_NONE && o_out_data.hit_entity == '0)
        else $error("side or entity reported without a hit");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int  SLOTS     = 64;
    localparam int  PHASES    = 4;
    localparam int  PER_PHASE = 235;
    localparam int  U         = 65536;
    localparam longint CYCLE_LIMIT = 100_000_000;

    logic           clk;
    logic           rst_n;
    logic           in_valid = 1'b0;
    logic           in_stall;
    sbtt_pkg::t_in  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    sbtt_pkg::t_out out_data;
    logic           psel, penable, pwrite;
    logic [sbtt_pkg::PADDR_BITS-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    swept_box_trace_table_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    // shadow of the box table and the ignore register
    logic [15:0]    skip_id;
    bit             row_used [SLOTS];
    logic [15:0]    row_id [SLOTS];
    longint         row_box [SLOTS][6];

    sbtt_pkg::t_in  pending_items [$];
    sbtt_pkg::t_out expected_traces [$];
    int             error_count = 0;
    bit             calm;
    longint         cycle_count;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0))) q--;
        return q;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic sbtt_pkg::t_out trace_result(sbtt_pkg::t_in it);
        sbtt_pkg::t_out res;
        longint mbox [6];
        longint mv [3];
        longint off [3];
        longint entry, leave, t1, t2, lo, hi, best, pos, neg, dep;
        logic [2:0] cside, bs;
        bit     over, ok;
        mbox = '{it.box_min_x, it.box_min_y, it.box_min_z,
                 it.box_max_x, it.box_max_y, it.box_max_z};
        mv = '{it.move_x, it.move_y, it.move_z};
        res = '0;
        if (it.opcode == sbtt_pkg::OP_WRITE) begin
            if (it.entity == 0) begin
                row_used[it.slot] = 1'b0;
            end else begin
                row_used[it.slot] = 1'b1;
                row_id[it.slot] = it.entity;
                for (int k = 0; k < 6; k++) row_box[it.slot][k] = mbox[k];
            end
            return res;
        end
        res.fraction = sbtt_pkg::FRAC_ONE;
        res.side = sbtt_pkg::SIDE_NONE;
        for (int k = 0; k < 3; k++) off[k] = mv[k];
        for (int i = 0; i < SLOTS; i++) begin
            if (!row_used[i] || row_id[i] == skip_id) continue;
            over = 1'b1;
            for (int k = 0; k < 3; k++)
                if (!(mbox[3+k] > row_box[i][k] && mbox[k] < row_box[i][3+k])) over = 1'b0;
            if (over) begin
                best = 0;
                bs = sbtt_pkg::SIDE_NONE;
                for (int k = 0; k < 3; k++) begin
                    pos = row_box[i][3+k] - mbox[k];
                    neg = mbox[3+k] - row_box[i][k];
                    dep = pos < neg ? pos : neg;
                    if (k == 0 || dep < best) begin
                        best = dep;
                        bs = sbtt_pkg::SIDE_NEG_X + 3'(2 * k) + (pos < neg ? 3'd1 : 3'd0);
                    end
                end
                res.hit = 1'b1;
                res.start_overlap = 1'b1;
                res.fraction = '0;
                res.side = bs;
                res.hit_entity = row_id[i];
                off = '{0, 0, 0};
                break;
            end
            entry = -(64'sd1 <<< 60);
            leave = 64'sd1 <<< 60;
            cside = sbtt_pkg::SIDE_NONE;
            ok = 1'b1;
            for (int k = 0; k < 3 && ok; k++) begin
                if (mv[k] == 0) begin
                    ok = mbox[3+k] >= row_box[i][k] && mbox[k] <= row_box[i][3+k];
                end else begin
                    t1 = floor_quot((row_box[i][k] - mbox[3+k]) * sbtt_pkg::ONE_Q16, mv[k]);
                    t2 = floor_quot((row_box[i][3+k] - mbox[k]) * sbtt_pkg::ONE_Q16, mv[k]);
                    lo = t1 < t2 ? t1 : t2;
                    hi = t1 < t2 ? t2 : t1;
                    if (lo > entry) begin
                        entry = lo;
                        cside = sbtt_pkg::SIDE_NEG_X + 3'(2 * k) + (mv[k] > 0 ? 3'd0 : 3'd1);
                    end
                    if (hi < leave) leave = hi;
                    ok = entry <= leave;
                end
            end
            if (!ok || entry < 0 || entry > sbtt_pkg::ONE_Q16 || entry > leave) continue;
            if (!res.hit || entry < longint'(res.fraction)) begin
                res.hit = 1'b1;
                res.fraction = 17'(entry);
                res.side = cside;
                res.hit_entity = row_id[i];
                for (int k = 0; k < 3; k++)
                    off[k] = sat32(floor_quot(mv[k] * entry, sbtt_pkg::ONE_Q16));
            end
        end
        res.offset_x = off[0][31:0];
        res.offset_y = off[1][31:0];
        res.offset_z = off[2][31:0];
        return res;
    endfunction

    function automatic sbtt_pkg::t_in box_item(logic op, int slot, int id, int x0, int y0,
                                               int z0, int x1, int y1, int z1,
                                               int mx, int my, int mz);
        sbtt_pkg::t_in it;
        it = '0;
        it.opcode = op;
        it.slot = 6'(slot);
        it.entity = 16'(id);
        it.box_min_x = x0; it.box_min_y = y0; it.box_min_z = z0;
        it.box_max_x = x1; it.box_max_y = y1; it.box_max_z = z1;
        it.move_x = mx; it.move_y = my; it.move_z = mz;
        return it;
    endfunction

    // coordinates within about +-32 units so boxes meet often
    function automatic logic [31:0] near_coord();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return 32'($urandom_range(0, 4194303)) - 32'd2097152;
    endfunction

    function automatic sbtt_pkg::t_in random_item();
        sbtt_pkg::t_in it;
        logic [31:0] sz;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            it = ($bits(sbtt_pkg::t_in))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom});
            if (it.opcode == sbtt_pkg::OP_WRITE && $urandom_range(0, 1)) it.entity = '0;
            return it;
        end
        it = '0;
        it.opcode = r < 40 ? sbtt_pkg::OP_WRITE : sbtt_pkg::OP_TRACE;
        it.slot = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 7));
        if (it.opcode == sbtt_pkg::OP_WRITE
            && (it.slot > 7 ? $urandom_range(0, 1) : $urandom_range(0, 3)) == 0)
            it.entity = '0;
        else
            it.entity = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 6));
        it.box_min_x = near_coord(); it.box_min_y = near_coord(); it.box_min_z = near_coord();
        sz = 32'($urandom_range(0, 524288));
        it.box_max_x = $urandom_range(0, 19) == 0 ? near_coord() : it.box_min_x + sz;
        sz = 32'($urandom_range(0, 524288));
        it.box_max_y = $urandom_range(0, 19) == 0 ? near_coord() : it.box_min_y + sz;
        sz = 32'($urandom_range(0, 524288));
        it.box_max_z = $urandom_range(0, 19) == 0 ? near_coord() : it.box_min_z + sz;
        it.move_x = $urandom_range(0, 4) == 0 ? 32'd0 : near_coord();
        it.move_y = $urandom_range(0, 4) == 0 ? 32'd0 : near_coord();
        it.move_z = $urandom_range(0, 4) == 0 ? 32'd0 : near_coord();
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic write_skip_id(logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= sbtt_pkg::ADDR_IGNORED; pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        skip_id = v;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
        if (prdata != {16'd0, v}) report_mismatch("readback", 64'(prdata), 64'({16'd0, v}));
    endtask

    // driver: presents queued items, predicts on each accepted transaction
    always @(posedge clk) begin
        logic nv;
        sbtt_pkg::t_in nd;
        if (rst_n) begin
            nv = in_valid;
            nd = in_data;
            if (in_valid && !in_stall) begin
                expected_traces.push_back(trace_result(in_data));
                nv = 1'b0;
            end
            if (!nv && pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
                nv = 1'b1;
                nd = pending_items.pop_front();
            end
            in_valid <= nv;
            in_data <= nd;
        end
    end

    // monitor
    always @(posedge clk) begin
        sbtt_pkg::t_out want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_traces.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(out_data.hit_entity), 64'(0));
                end else begin
                    want = expected_traces.pop_front();
                    if (out_data.hit != want.hit)
                        report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
                    if (out_data.start_overlap != want.start_overlap)
                        report_mismatch("start_overlap", 64'(out_data.start_overlap),
                                        64'(want.start_overlap));
                    if (out_data.fraction != want.fraction)
                        report_mismatch("fraction", 64'(out_data.fraction), 64'(want.fraction));
                    if (out_data.side != want.side)
                        report_mismatch("side", 64'(out_data.side), 64'(want.side));
                    if (out_data.hit_entity != want.hit_entity)
                        report_mismatch("hit_entity", 64'(out_data.hit_entity),
                                        64'(want.hit_entity));
                    if (out_data.offset_x != want.offset_x)
                        report_mismatch("offset_x", 64'(out_data.offset_x), 64'(want.offset_x));
                    if (out_data.offset_y != want.offset_y)
                        report_mismatch("offset_y", 64'(out_data.offset_y), 64'(want.offset_y));
                    if (out_data.offset_z != want.offset_z)
                        report_mismatch("offset_z", 64'(out_data.offset_z), 64'(want.offset_z));
                end
            end
            out_stall <= !calm && $urandom_range(0, 99) < 11;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [15:0] skip_values [PHASES];
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        rst_n = 1'b0; skip_id = '0; calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        skip_values = '{16'd0, 16'hFFFF, 16'd3, 16'($urandom)};
        // directed: walls, touching, start overlap, extremes
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 0, 1, 10*U, -U, -U, 12*U, U, U,
                                         0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 63, 16'hFFFF, -U, 10*U, -U, U,
                                         12*U, U, 0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 5, 3, -U, -U, -12*U, U, U, -10*U,
                                         0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 0, 0, U/2, U/2, U/2,
                                         20*U, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 20*U, 0, 0, 21*U, U/2, U/2,
                                         -20*U, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 0, 0, U/2, U/2, U/2,
                                         0, 20*U, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 20*U, 0, U/2, 21*U, U/2,
                                         0, -20*U, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 0, 0, U/2, U/2, U/2,
                                         0, 0, -20*U));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 0, -20*U, U/2, U/2,
                                         -19*U, 0, 0, 20*U));
        // touching with no movement, then start inside
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 9*U, 0, 0, 10*U, U/2, U/2,
                                         0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 11*U, 0, 0, 13*U, U/2, U/2,
                                         U, U, U));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 9*U, -U/4, -3*U, 11*U, U/4,
                                         3*U, 0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 0, 0, U/2, U/2, U/2,
                                         -20*U, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 63, 16'hFFFF, 32'h80000000,
                                         32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                         32'h7FFFFFFF, 32'h7FFFFFFF,
                                         32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, -100*U, -100*U, -100*U,
                                         -99*U, -99*U, -99*U,
                                         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 7, 9, 2*U, 2*U, 2*U, -2*U, -2*U,
                                         -2*U, 0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, -U, -U, -U, U, U, U,
                                         U, U, U));
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_WRITE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(box_item(sbtt_pkg::OP_TRACE, 0, 0, 0, 20*U, 0, U/2, 21*U, U/2,
                                         0, -20*U, 0));

        // register writes only once nothing is in flight
        wait (pending_items.size() == 0 && !in_valid && expected_traces.size() == 0);
        repeat (4) @(posedge clk);

        for (int p = 0; p < PHASES; p++) begin
            write_skip_id(skip_values[p]);
            calm = (p == 2);
            for (int n = 0; n < PER_PHASE; n++) pending_items.push_back(random_item());
            // hold the sender until the phase drains
            wait (pending_items.size() == 0 && !in_valid && expected_traces.size() == 0);
            repeat (4) @(posedge clk);
        end
        calm = 1'b0;
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_traces.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
